// ----- rtl/cts_pkg.sv -----
// Shared types, constants and helpers for the cosine top-k selector.
package cts_pkg;

    localparam int WINDOW_ROWS_DEF = 256;
    localparam int MAX_TOP_DEF     = 32;
    localparam int VECTOR_DIM      = 7;

    localparam int ELEM_W    = 16;
    localparam int TAG_W     = 32;
    localparam int TOPC_W    = 6;
    localparam int IDX_OUT_W = 8;
    localparam int SCORE_W   = 16;

    // multiplier, accumulator, root and divider widths follow from the field widths
    localparam int MUL_W    = 18;
    localparam int ACC_W    = 36;
    localparam int SQ_IN_W  = 33;
    localparam int ROOT_W   = 17;
    localparam int SQ_STEPS = 17;
    localparam int Q_SHIFT  = 14;
    localparam int Q_ONE    = 16384;
    localparam int NUM_W    = 48;
    localparam int DEN_W    = 34;
    localparam int QBITS    = 15;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_RUN    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [ELEM_W-1:0] elem_0;
        logic signed [ELEM_W-1:0] elem_1;
        logic signed [ELEM_W-1:0] elem_2;
        logic signed [ELEM_W-1:0] elem_3;
        logic signed [ELEM_W-1:0] elem_4;
        logic signed [ELEM_W-1:0] elem_5;
        logic signed [ELEM_W-1:0] elem_6;
        logic [TAG_W-1:0]         row_tag;
        logic [TOPC_W-1:0]        top_count;
    } t_in_word;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]      row_index;
        logic [TAG_W-1:0]          tag_out;
        logic signed [SCORE_W-1:0] score;
        logic                      last;
    } t_out_word;

    // pick one feature by step number; steps past the vector read as zero
    function automatic logic signed [ELEM_W-1:0] elem_at(t_in_word w, logic [2:0] k);
        logic signed [ELEM_W-1:0] e;
        case (k)
            3'd0:    e = w.elem_0;
            3'd1:    e = w.elem_1;
            3'd2:    e = w.elem_2;
            3'd3:    e = w.elem_3;
            3'd4:    e = w.elem_4;
            3'd5:    e = w.elem_5;
            3'd6:    e = w.elem_6;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/cosine_topk_selector_top.sv -----
// Load query: squares, then the root. Append: squares, dot product, root wait, denominator,
// division, write. Run: each result word takes a scan of the stored rows, a drain and a tag
// read before it is emitted, plus any wait on the output side.
// Clear, a full-window append and an empty run leave the block idle; ready is low while busy.
// Synchronous active-low reset clears control, query and row count; the stores are
// not swept, since rows at or above the count are never read.
module cosine_topk_selector_top
    import cts_pkg::*;
#(
    parameter int WINDOW_ROWS = WINDOW_ROWS_DEF,
    parameter int MAX_TOP     = MAX_TOP_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_out
);

    localparam int IDX_W = (WINDOW_ROWS > 1) ? $clog2(WINDOW_ROWS) : 1;
    localparam int RC_W  = $clog2(WINDOW_ROWS + 1);
    localparam int TOP_W = $clog2(MAX_TOP + 1);
    localparam int CMP_W = (RC_W > 7) ? RC_W : 7;

    typedef enum logic [3:0] {
        S_IDLE, S_SUMSQ, S_QWAIT, S_DOT, S_RWAIT, S_DEN, S_DSTART, S_DWAIT,
        S_WRITE, S_SCAN, S_DRAIN, S_TAG, S_EMIT
    } t_state;

    t_state                    r_state;
    t_in_word                  r_in;
    t_in_word                  r_qword;
    logic [ROOT_W-1:0]         r_qnorm;
    logic [RC_W-1:0]           r_count;
    logic [2:0]                r_k;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_prod;
    logic                      r_root_go;
    logic                      r_neg;
    logic [NUM_W-1:0]          r_num;
    logic signed [SCORE_W-1:0] r_score;

    logic [TOP_W-1:0]          r_left;
    logic [IDX_W-1:0]          r_addr;
    logic                      r_rd_valid;
    logic [IDX_W-1:0]          r_rd_idx;
    logic signed [SCORE_W-1:0] r_rd_score;
    logic [TAG_W-1:0]          r_rd_tag;
    logic                      r_found;
    logic [IDX_W-1:0]          r_best;
    logic signed [SCORE_W-1:0] r_best_score;
    logic                      r_have_last;
    logic [IDX_W-1:0]          r_last_idx;
    logic signed [SCORE_W-1:0] r_last_score;
    logic                      r_out_valid;
    t_out_word                 r_out;

    logic signed [SCORE_W-1:0] score_mem [WINDOW_ROWS];
    logic [TAG_W-1:0]          tag_mem   [WINDOW_ROWS];

    logic signed [MUL_W-1:0]   n_mul_a;
    logic signed [MUL_W-1:0]   n_mul_b;
    logic signed [ACC_W-1:0]   n_mul_p;
    logic signed [ELEM_W-1:0]  n_ea;
    logic signed [ELEM_W-1:0]  n_eb;
    logic [ACC_W-1:0]          n_dot_mag;
    logic [QBITS-1:0]          n_mag;
    logic [CMP_W-1:0]          n_want;
    logic [CMP_W-1:0]          n_runs;
    logic                      n_cand;
    logic                      n_better;
    logic [IDX_W+7:0]          n_idx_ext;
    logic                      n_accept;
    logic                      n_out_free;

    logic                      sq_busy;
    logic [ROOT_W-1:0]         sq_root;
    logic                      div_start;
    logic                      div_busy;
    logic [QBITS-1:0]          div_quot;

    cts_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_root_go),
        .i_x     (r_acc[SQ_IN_W-1:0]),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    assign div_start = (r_state == S_DSTART);

    cts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_prod[DEN_W-1:0]),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // shared multiplier: squares, dot terms, then the norm product
    always_comb begin
        n_ea    = elem_at(r_in, r_k);
        n_eb    = elem_at(r_qword, r_k);
        n_mul_a = '0;
        n_mul_b = '0;
        case (r_state)
            S_SUMSQ: begin
                n_mul_a = {{(MUL_W - ELEM_W){n_ea[ELEM_W-1]}}, n_ea};
                n_mul_b = {{(MUL_W - ELEM_W){n_ea[ELEM_W-1]}}, n_ea};
            end
            S_DOT: begin
                n_mul_a = {{(MUL_W - ELEM_W){n_ea[ELEM_W-1]}}, n_ea};
                n_mul_b = {{(MUL_W - ELEM_W){n_eb[ELEM_W-1]}}, n_eb};
            end
            S_DEN: begin
                n_mul_a = {1'b0, r_qnorm};
                n_mul_b = {1'b0, sq_root};
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
        n_mul_p = n_mul_a * n_mul_b;
    end

    assign n_dot_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign n_mag     = (div_quot > QBITS'(Q_ONE)) ? QBITS'(Q_ONE) : div_quot;

    assign n_want = (CMP_W'(i_in.top_count) > CMP_W'(MAX_TOP)) ? CMP_W'(MAX_TOP)
                                                                : CMP_W'(i_in.top_count);
    assign n_runs = (n_want < CMP_W'(r_count)) ? n_want : CMP_W'(r_count);

    // a row is a candidate when it ranks below the word last emitted
    assign n_cand   = !r_have_last || (r_rd_score < r_last_score) ||
                      ((r_rd_score == r_last_score) && (r_rd_idx > r_last_idx));
    assign n_better = !r_found || (r_rd_score > r_best_score);

    assign n_idx_ext  = {8'b0, r_best};
    assign n_accept   = i_valid && o_ready;
    assign n_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qword     <= '0;
            r_qnorm     <= '0;
            r_count     <= '0;
            r_root_go   <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_have_last <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod     <= n_mul_p;
            r_root_go  <= (r_state == S_SUMSQ) && (r_k == 3'd7);
            r_rd_valid <= (r_state == S_SCAN);
            r_rd_idx   <= r_addr;

            if (r_rd_valid && n_cand && n_better) begin
                r_found      <= 1'b1;
                r_best       <= r_rd_idx;
                r_best_score <= r_rd_score;
            end

            if (r_out_valid && i_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_in <= i_in;
                        r_k  <= '0;
                        case (i_in.command)
                            CMD_CLEAR: begin
                                r_count <= '0;
                            end
                            CMD_LOAD: begin
                                r_qword <= i_in;
                                r_state <= S_SUMSQ;
                            end
                            CMD_APPEND: begin
                                if (r_count < RC_W'(WINDOW_ROWS)) begin
                                    r_state <= S_SUMSQ;
                                end
                            end
                            CMD_RUN: begin
                                if (n_runs != '0) begin
                                    r_left      <= TOP_W'(n_runs);
                                    r_have_last <= 1'b0;
                                    r_found     <= 1'b0;
                                    r_addr      <= '0;
                                    r_state     <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SUMSQ, S_DOT: begin
                    // product of step k is registered and added in the following step; the step count wraps to zero
                    if (r_k == 3'd0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= r_acc + r_prod;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        if (r_state == S_DOT) begin
                            r_state <= S_RWAIT;
                        end else if (r_in.command == CMD_LOAD) begin
                            r_state <= S_QWAIT;
                        end else begin
                            r_state <= S_DOT;
                        end
                    end
                end
                S_QWAIT: begin
                    if (!r_root_go && !sq_busy) begin
                        r_qnorm <= sq_root;
                        r_state <= S_IDLE;
                    end
                end
                S_RWAIT: begin
                    if (!sq_busy) begin
                        r_neg <= r_acc[ACC_W-1];
                        r_num <= NUM_W'({n_dot_mag, {Q_SHIFT{1'b0}}});
                        if ((sq_root == '0) || (r_qnorm == '0)) begin
                            r_score <= '0;
                            r_state <= S_WRITE;
                        end else begin
                            r_state <= S_DEN;
                        end
                    end
                end
                S_DEN: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (!div_busy) begin
                        r_score <= r_neg ? -SCORE_W'(n_mag) : SCORE_W'(n_mag);
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_count <= r_count + RC_W'(1);
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_addr <= r_addr + IDX_W'(1);
                    if ((RC_W'(r_addr) + RC_W'(1)) == r_count) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_TAG;
                end
                S_TAG: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (n_out_free) begin
                        r_out.row_index <= n_idx_ext[7:0];
                        r_out.tag_out   <= r_rd_tag;
                        r_out.score     <= r_best_score;
                        r_out.last      <= (r_left == TOP_W'(1));
                        r_out_valid     <= 1'b1;
                        r_have_last     <= 1'b1;
                        r_last_idx      <= r_best;
                        r_last_score    <= r_best_score;
                        r_left          <= r_left - TOP_W'(1);
                        r_found         <= 1'b0;
                        r_addr          <= '0;
                        if (r_left == TOP_W'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // score and tag stores: one write port, registered reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            score_mem[r_count[IDX_W-1:0]] <= r_score;
            tag_mem[r_count[IDX_W-1:0]]   <= r_in.row_tag;
        end
        r_rd_score <= score_mem[r_addr];
        r_rd_tag   <= tag_mem[r_best];
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ----- rtl/cts_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
module cts_isqrt
    import cts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SQ_IN_W-1:0] i_x,
    output logic               o_busy,
    output logic [ROOT_W-1:0]  o_root
);

    localparam int W = SQ_IN_W + 1;
    localparam logic [W-1:0] BIT_INIT = W'(1) << (2 * (SQ_STEPS - 1));

    logic         r_busy;
    logic [W-1:0] r_x;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;
    logic [4:0]   r_cnt;
    logic [W-1:0] n_trial;
    logic         n_ge;

    assign n_trial = r_res + r_bit;
    assign n_ge    = (r_x >= n_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_x    <= {1'b0, i_x};
            r_res  <= '0;
            r_bit  <= BIT_INIT;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (n_ge) begin
                r_x   <= r_x - n_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(SQ_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// ----- rtl/cts_div.sv -----
// Restoring divider for the score magnitude, one quotient bit per cycle, saturating.
module cts_div
    import cts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [QBITS-1:0] o_quot
);

    localparam int DSH_W = DEN_W + QBITS;

    logic             r_busy;
    logic             r_chk;
    logic [NUM_W-1:0] r_rem;
    logic [DSH_W-1:0] r_dsh;
    logic [QBITS-1:0] r_q;
    logic [3:0]       r_cnt;
    logic [DSH_W-1:0] n_rem_ext;
    logic             n_ge;

    assign n_rem_ext = {{(DSH_W - NUM_W){1'b0}}, r_rem};
    assign n_ge      = (n_rem_ext >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_chk  <= 1'b1;
            r_rem  <= i_num;
            r_dsh  <= {i_den, {QBITS{1'b0}}};
            r_q    <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_chk) begin
                // quotient too wide: saturate at once
                if (n_ge) begin
                    r_q    <= QBITS'(Q_ONE);
                    r_busy <= 1'b0;
                end
                r_chk <= 1'b0;
                r_dsh <= r_dsh >> 1;
            end else begin
                if (n_ge) begin
                    r_rem <= NUM_W'(n_rem_ext - r_dsh);
                end
                r_q   <= {r_q[QBITS-2:0], n_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(QBITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

// ----- rtl/cts_checker.sv -----
// Port-level assertions for the cosine top-k selector, bound to the top level.
module cts_checker
    import cts_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_word  i_in,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("output word changed while stalled");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.score <= 16'sd16384) && (o_out.score >= -16'sd16384))
        else $error("score outside unit range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_in.command == CMD_LOAD) |=> !o_ready)
        else $error("query load did not occupy the block");

endmodule

bind cosine_topk_selector_top cts_checker u_cts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);
